/* hdl/eip_pkg.sv */
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
// No dependencies; imported by eip_parse, eip_out_stage, the top module and the testbench.
package eip_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_IPV4  = 2'd1,
        ST_BAD_PROTO = 2'd2,
        ST_TRUNC     = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
        logic [15:0] frame_length;
    } t_result;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] PROTO_MIN_LEN  = 16'd24;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
    localparam logic [7:0]  TCP_MIN_BYTES  = 8'd20;

    // fixed byte positions within the frame
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_IHL      = 16'd14;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_SRC_IP   = 16'd26;
    localparam logic [15:0] POS_DST_IP   = 16'd30;
    localparam logic [15:0] POS_L4_MIN   = 16'd34;

endpackage

/* hdl/eip_in_stage.sv */
// Input register of the header parser: holds one byte item and its last mark.
// Depends on nothing beyond its ports.
module eip_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_move,
    output logic       o_stall,
    output logic       o_s1_valid,
    output logic [7:0] o_s1_data,
    output logic       o_s1_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       n_valid;
    logic       accept;

    assign o_stall = r_valid && !i_move;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_move) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1_data  = r_data;
    assign o_s1_last  = r_last;

`ifndef SYNTHESIS
    a_move_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_move |-> r_valid)
        else $error("input stage moved without an item");

    a_held_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_move |=> r_valid && $stable(r_data) && $stable(r_last))
        else $error("blocked input item lost");
`endif

endmodule

/* hdl/eip_parse.sv */
// Frame state of the header parser: byte counter, captured header fields and
// the end-of-frame result. Depends on eip_pkg.
module eip_parse #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output logic             o_res_valid,
    output eip_pkg::t_result o_res
);

    import eip_pkg::*;

    localparam logic [15:0] MAX_CNT = 16'(MAX_FRAME_BYTES);

    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_ether_kind, n_ether_kind;
    logic [3:0]  r_ihl,        n_ihl;
    logic [7:0]  r_proto,      n_proto;
    logic [31:0] r_src_addr,   n_src_addr;
    logic [31:0] r_dst_addr,   n_dst_addr;
    logic [15:0] r_src_port,   n_src_port;
    logic [15:0] r_dst_port,   n_dst_port;
    logic [7:0]  r_l4_end,     n_l4_end;

    logic        take;
    logic [7:0]  l4s;
    logic [15:0] l4s_w;
    logic [3:0]  doff;
    t_status     status;

    assign take  = r_byte_count < MAX_CNT;
    // transport header start: 14 + 4*IHL
    assign l4s   = 8'(ETH_HDR_BYTES) + {2'b00, r_ihl, 2'b00};
    assign l4s_w = {8'h00, l4s};
    assign doff  = (i_data[7:4] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : i_data[7:4];

    always_comb begin
        n_byte_count = r_byte_count;
        n_ether_kind = r_ether_kind;
        n_ihl        = r_ihl;
        n_proto      = r_proto;
        n_src_addr   = r_src_addr;
        n_dst_addr   = r_dst_addr;
        n_src_port   = r_src_port;
        n_dst_port   = r_dst_port;
        n_l4_end     = r_l4_end;
        if (take) begin
            n_byte_count = r_byte_count + 16'd1;
            if (r_byte_count == POS_ETYPE_HI) begin
                n_ether_kind = {i_data, 8'h00};
            end else if (r_byte_count == POS_ETYPE_LO) begin
                n_ether_kind = r_ether_kind | {8'h00, i_data};
            end else if (r_byte_count == POS_IHL) begin
                n_ihl = (i_data[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : i_data[3:0];
            end else if (r_byte_count == POS_PROTO) begin
                n_proto = i_data;
                if (i_data == PROTO_UDP) begin
                    n_l4_end = l4s + UDP_HDR_BYTES;
                end else if (i_data == PROTO_TCP) begin
                    n_l4_end = l4s + TCP_MIN_BYTES;
                end else begin
                    n_l4_end = 8'h00;
                end
            end else if (r_byte_count >= POS_SRC_IP && r_byte_count < POS_DST_IP) begin
                n_src_addr = {r_src_addr[23:0], i_data};
            end else if (r_byte_count >= POS_DST_IP && r_byte_count < POS_L4_MIN) begin
                n_dst_addr = {r_dst_addr[23:0], i_data};
            end

            if (r_byte_count >= POS_L4_MIN) begin
                if (r_byte_count == l4s_w || r_byte_count == l4s_w + 16'd1) begin
                    n_src_port = {r_src_port[7:0], i_data};
                end else if (r_byte_count == l4s_w + 16'd2
                             || r_byte_count == l4s_w + 16'd3) begin
                    n_dst_port = {r_dst_port[7:0], i_data};
                end else if (r_byte_count == l4s_w + 16'd12 && r_proto == PROTO_TCP) begin
                    // TCP data offset sets the real header end
                    n_l4_end = l4s + {2'b00, doff, 2'b00};
                end
            end
        end
    end

    // result uses the state as it stands after this byte
    always_comb begin
        if (n_byte_count < ETH_HDR_BYTES) begin
            status = ST_TRUNC;
        end else if (n_ether_kind != ETHERTYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (n_byte_count < PROTO_MIN_LEN) begin
            status = ST_TRUNC;
        end else if (n_proto != PROTO_TCP && n_proto != PROTO_UDP) begin
            status = ST_BAD_PROTO;
        end else if (n_byte_count < {8'h00, n_l4_end}) begin
            status = ST_TRUNC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_res              = '0;
        o_res.status       = status;
        o_res.frame_length = n_byte_count;
        if (status == ST_OK) begin
            o_res.protocol       = n_proto;
            o_res.src_ip         = n_src_addr;
            o_res.dst_ip         = n_dst_addr;
            o_res.src_port       = n_src_port;
            o_res.dst_port       = n_dst_port;
            o_res.payload_offset = n_l4_end;
            o_res.payload_length = n_byte_count - {8'h00, n_l4_end};
        end
    end

    assign o_res_valid = i_step && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_byte_count <= '0;
            r_ether_kind <= '0;
            r_ihl        <= '0;
            r_proto      <= '0;
            r_src_addr   <= '0;
            r_dst_addr   <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
            r_l4_end     <= '0;
        end else if (i_step) begin
            r_byte_count <= n_byte_count;
            r_ether_kind <= n_ether_kind;
            r_ihl        <= n_ihl;
            r_proto      <= n_proto;
            r_src_addr   <= n_src_addr;
            r_dst_addr   <= n_dst_addr;
            r_src_port   <= n_src_port;
            r_dst_port   <= n_dst_port;
            r_l4_end     <= n_l4_end;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_byte_count == 16'd0 && r_l4_end == 8'd0)
        else $error("frame state not cleared after last byte");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_CNT)
        else $error("byte counter past frame limit");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_OK |->
            o_res.payload_offset == 8'd0 && o_res.src_ip == 32'd0
            && o_res.payload_length == 16'd0)
        else $error("failed frame carries header fields");
`endif

endmodule

/* hdl/eip_out_stage.sv */
// Result register of the header parser, held while the receiver stalls.
// Depends on eip_pkg.
module eip_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  eip_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output eip_pkg::t_result o_res
);

    import eip_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result register overwritten while stalled");

    a_keep_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid)
        else $error("stalled result dropped");
`endif

endmodule

/* hdl/eth_ipv4_l4_header_parser.sv */
// Ethernet / IPv4 / TCP-UDP header parser, one frame byte per item.
//
// Input channel: i_valid / o_stall with i_data_byte and i_last_byte; an item
// is accepted at a rising edge with i_valid high and o_stall low. Bytes come
// in wire order; i_last_byte marks the final byte of a frame.
// Output channel: o_valid / i_stall; one result item per frame with status,
// protocol, IP addresses, ports, payload offset/length and frame length.
// Throughput: one byte per cycle while no last byte waits for a free result
// register; parsing between the input and result registers is combinational.
// A frame's result passes from the input register through the parse step into
// the result register after its last byte is accepted, then shows on o_valid.
// While a result waits under i_stall, non-last bytes keep flowing in; a last
// byte waits in the input register until the result register frees, and
// o_stall is raised only while it waits.
// Reset (i_rst_n low, synchronous): both registers empty, frame state zero.
// Frame length saturates at MAX_FRAME_BYTES; later bytes are not examined.
module eth_ipv4_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_protocol,
    output logic [31:0] o_src_ip,
    output logic [31:0] o_dst_ip,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [7:0]  o_payload_offset,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_frame_length
);

    import eip_pkg::*;

    logic       s1_valid;
    logic [7:0] s1_data;
    logic       s1_last;
    logic       move;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // a non-last byte only updates state; a last byte needs the result slot
    assign move = s1_valid && (!s1_last || out_free);

    eip_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_move      (move),
        .o_stall     (o_stall),
        .o_s1_valid  (s1_valid),
        .o_s1_data   (s1_data),
        .o_s1_last   (s1_last)
    );

    eip_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (move),
        .i_data      (s1_data),
        .i_last      (s1_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    eip_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_status         = out_res.status;
    assign o_protocol       = out_res.protocol;
    assign o_src_ip         = out_res.src_ip;
    assign o_dst_ip         = out_res.dst_ip;
    assign o_src_port       = out_res.src_port;
    assign o_dst_port       = out_res.dst_port;
    assign o_payload_offset = out_res.payload_offset;
    assign o_payload_length = out_res.payload_length;
    assign o_frame_length   = out_res.frame_length;

`ifndef SYNTHESIS
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && s1_last && o_valid && i_stall |-> !move)
        else $error("last byte parsed while result slot full");

    a_body_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_last |-> move && !o_stall)
        else $error("non-last byte blocked");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && s1_last |=> o_valid)
        else $error("no result after last byte");
`endif

endmodule

/* dv/testbench.sv */
// Testbench for eth_ipv4_l4_header_parser: drives frames one byte per item
// through a directed table and random frames, and scores each result item.
// Depends on eip_pkg (status enum, result struct, header constants) and the DUT.
`timescale 1ns / 100ps

module testbench;
    import eip_pkg::*;

    localparam int MAX_BYTES   = 65535;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HDR_SPAN    = 128;  // covers every header position the parser examines

    typedef struct {
        int          len;
        logic [15:0] etype;
        logic [7:0]  vihl;     // IPv4 version / IHL byte
        logic [7:0]  proto;
        logic [7:0]  tcp_b12;  // TCP byte 12, data offset in the high nibble
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        bit          typed;    // expected result given by the table row
        t_status     exp_st;
    } t_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_protocol;
    logic [31:0] o_src_ip;
    logic [31:0] o_dst_ip;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [7:0]  o_payload_offset;
    logic [15:0] o_payload_length;
    logic [15:0] o_frame_length;

    // predictor's copy of the per-frame state
    logic [15:0] fr_count = '0;
    logic [15:0] fr_etype = '0;
    logic [3:0]  fr_ihl = '0;
    logic [7:0]  fr_proto = '0;
    logic [31:0] fr_sip = '0;
    logic [31:0] fr_dip = '0;
    logic [15:0] fr_sport = '0;
    logic [15:0] fr_dport = '0;
    logic [7:0]  fr_l4_end = '0;

    t_result pending_hdrs[$];
    bit      cur_typed = 1'b0;
    t_result cur_typed_res = '0;
    bit      quiet = 1'b0;
    int      stall_run = 0;
    int      err_count = 0;
    int      cycles = 0;

    eth_ipv4_l4_header_parser #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_protocol(o_protocol),
        .o_src_ip(o_src_ip),
        .o_dst_ip(o_dst_ip),
        .o_src_port(o_src_port),
        .o_dst_port(o_dst_port),
        .o_payload_offset(o_payload_offset),
        .o_payload_length(o_payload_length),
        .o_frame_length(o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_frame_state();
        fr_count  = '0;
        fr_etype  = '0;
        fr_ihl    = '0;
        fr_proto  = '0;
        fr_sip    = '0;
        fr_dip    = '0;
        fr_sport  = '0;
        fr_dport  = '0;
        fr_l4_end = '0;
    endfunction

    // Advances the frame state by one byte; returns 1 with the header result on the last byte.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result r);
        int pos;
        int l4s;
        int doff;
        int len;
        r = '0;
        if (int'(fr_count) < MAX_BYTES) begin
            pos = int'(fr_count);
            l4s = int'(ETH_HDR_BYTES) + 4 * int'(fr_ihl);
            if (pos == POS_ETYPE_HI) begin
                fr_etype = {b, 8'h00};
            end else if (pos == POS_ETYPE_LO) begin
                fr_etype = fr_etype | {8'h00, b};
            end else if (pos == POS_IHL) begin
                fr_ihl = (b[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : b[3:0];
            end else if (pos == POS_PROTO) begin
                fr_proto = b;
                if (b == PROTO_UDP)
                    fr_l4_end = 8'(l4s + int'(UDP_HDR_BYTES));
                else if (b == PROTO_TCP)
                    fr_l4_end = 8'(l4s + int'(TCP_MIN_BYTES));
                else
                    fr_l4_end = '0;
            end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
                fr_sip = {fr_sip[23:0], b};
            end else if (pos >= POS_DST_IP && pos < POS_L4_MIN) begin
                fr_dip = {fr_dip[23:0], b};
            end
            if (pos >= POS_L4_MIN) begin
                if (pos == l4s || pos == l4s + 1) begin
                    fr_sport = {fr_sport[7:0], b};
                end else if (pos == l4s + 2 || pos == l4s + 3) begin
                    fr_dport = {fr_dport[7:0], b};
                end else if (pos == l4s + 12 && fr_proto == PROTO_TCP) begin
                    doff = (b[7:4] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(b[7:4]);
                    fr_l4_end = 8'(l4s + 4 * doff);
                end
            end
            fr_count = fr_count + 16'd1;
        end
        if (!last)
            return 1'b0;

        len = int'(fr_count);
        if (len < ETH_HDR_BYTES)
            r.status = ST_TRUNC;
        else if (fr_etype != ETHERTYPE_IPV4)
            r.status = ST_NOT_IPV4;
        else if (len < PROTO_MIN_LEN)
            r.status = ST_TRUNC;
        else if (fr_proto != PROTO_TCP && fr_proto != PROTO_UDP)
            r.status = ST_BAD_PROTO;
        else if (len < int'(fr_l4_end))
            r.status = ST_TRUNC;
        else
            r.status = ST_OK;
        r.frame_length = fr_count;
        if (r.status == ST_OK) begin
            r.protocol       = fr_proto;
            r.src_ip         = fr_sip;
            r.dst_ip         = fr_dip;
            r.src_port       = fr_sport;
            r.dst_port       = fr_dport;
            r.payload_offset = fr_l4_end;
            r.payload_length = 16'(len - int'(fr_l4_end));
        end
        clear_frame_state();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result predicted;
        t_result want;
        if (i_rst_n && i_valid && !o_stall) begin
            if (parse_byte(i_data_byte, i_last_byte, predicted))
                pending_hdrs.push_back(cur_typed ? cur_typed_res : predicted);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hdrs.size() == 0) begin
                $error("result item with no frame pending: status %0d, length %0d",
                       o_status, o_frame_length);
                err_count++;
            end else begin
                want = pending_hdrs.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("protocol", 32'(want.protocol), 32'(o_protocol));
                check_field("src_ip", want.src_ip, o_src_ip);
                check_field("dst_ip", want.dst_ip, o_dst_ip);
                check_field("src_port", 32'(want.src_port), 32'(o_src_port));
                check_field("dst_port", 32'(want.dst_port), 32'(o_dst_port));
                check_field("payload_offset", 32'(want.payload_offset), 32'(o_payload_offset));
                check_field("payload_length", 32'(want.payload_length), 32'(o_payload_length));
                check_field("frame_length", 32'(want.frame_length), 32'(o_frame_length));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[eth_ipv4_l4_header_parser] ERROR");
            $finish;
        end
    end

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    always @(negedge i_clk) begin
        if (stall_run == 0 && !quiet && $urandom_range(0, 3) == 0)
            stall_run = idle_len();
        if (stall_run > 0) begin
            i_stall <= 1'b1;
            stall_run--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame f);
        logic [7:0] hdr [0:HDR_SPAN-1];
        int ihl;
        int l4s;
        for (int i = 0; i < HDR_SPAN; i++)
            hdr[i] = 8'($urandom);
        ihl = (f.vihl[3:0] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(f.vihl[3:0]);
        l4s = int'(ETH_HDR_BYTES) + 4 * ihl;
        hdr[POS_ETYPE_HI] = f.etype[15:8];
        hdr[POS_ETYPE_LO] = f.etype[7:0];
        hdr[POS_IHL]      = f.vihl;
        hdr[POS_PROTO]    = f.proto;
        for (int k = 0; k < 4; k++) begin
            hdr[int'(POS_SRC_IP) + k] = f.sip[31 - 8 * k -: 8];
            hdr[int'(POS_DST_IP) + k] = f.dip[31 - 8 * k -: 8];
        end
        hdr[l4s]      = f.sport[15:8];
        hdr[l4s + 1]  = f.sport[7:0];
        hdr[l4s + 2]  = f.dport[15:8];
        hdr[l4s + 3]  = f.dport[7:0];
        hdr[l4s + 12] = f.tcp_b12;

        cur_typed                  = f.typed;
        cur_typed_res              = '0;
        cur_typed_res.status       = f.exp_st;
        cur_typed_res.frame_length = (f.len > MAX_BYTES) ? 16'(MAX_BYTES) : 16'(f.len);
        for (int i = 0; i < f.len; i++)
            send_byte((i < HDR_SPAN) ? hdr[i] : 8'($urandom), i == f.len - 1);
    endtask

    // Sender holds off until every pending result item is out.
    task automatic wait_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_hdrs.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_frame frm(input int len, input logic [15:0] etype,
                                   input logic [7:0] vihl, input logic [7:0] proto,
                                   input logic [7:0] tcp_b12, input bit typed,
                                   input t_status exp_st);
        t_frame f;
        f.len     = len;
        f.etype   = etype;
        f.vihl    = vihl;
        f.proto   = proto;
        f.tcp_b12 = tcp_b12;
        f.sip     = $urandom;
        f.dip     = $urandom;
        f.sport   = 16'($urandom);
        f.dport   = 16'($urandom);
        f.typed   = typed;
        f.exp_st  = exp_st;
        return f;
    endfunction

    // Mostly well-formed TCP/UDP frames; the rest truncated, foreign or plain noise.
    function automatic t_frame rnd_frame();
        t_frame f;
        int pick;
        int ihl;
        int doff;
        int hend;
        pick = $urandom_range(0, 99);
        f = frm(0, ETHERTYPE_IPV4, ($urandom_range(0, 1) == 0) ? 8'h45 : 8'($urandom),
                ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP, 8'($urandom),
                1'b0, ST_OK);
        ihl  = (f.vihl[3:0] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(f.vihl[3:0]);
        doff = (f.tcp_b12[7:4] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(f.tcp_b12[7:4]);
        hend = int'(ETH_HDR_BYTES) + 4 * ihl
             + ((f.proto == PROTO_UDP) ? int'(UDP_HDR_BYTES) : 4 * doff);
        if (pick < 60) begin
            f.len = hend + $urandom_range(0, 40);
        end else if (pick < 72) begin
            f.len = $urandom_range(24, hend);
        end else if (pick < 82) begin
            f.proto = 8'($urandom);
            f.len   = $urandom_range(24, 90);
        end else if (pick < 91) begin
            f.etype = 16'($urandom);
            f.len   = $urandom_range(14, 90);
        end else begin
            if ($urandom_range(0, 1) == 0)
                f.etype = 16'($urandom);
            f.len = $urandom_range(1, 30);
        end
        return f;
    endfunction

    initial begin
        t_frame dir_tab[$];
        t_frame f;
        int rand_bytes;

        dir_tab = '{
            // right after reset: lone byte
            frm(1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_TRUNC),
            frm(13, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_TRUNC),
            // EtherType complete but no protocol byte
            frm(14, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_TRUNC),
            frm(14, 16'h86DD, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_NOT_IPV4),
            frm(60, 16'hFFFF, 8'h45, PROTO_TCP, 8'h50, 1'b1, ST_NOT_IPV4),
            frm(60, 16'h0000, 8'h45, PROTO_TCP, 8'h50, 1'b1, ST_NOT_IPV4),
            frm(23, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_TRUNC),
            frm(24, ETHERTYPE_IPV4, 8'h45, 8'h01, 8'h50, 1'b1, ST_BAD_PROTO),
            frm(60, ETHERTYPE_IPV4, 8'h45, 8'h00, 8'h50, 1'b1, ST_BAD_PROTO),
            frm(60, ETHERTYPE_IPV4, 8'h45, 8'hFF, 8'h50, 1'b1, ST_BAD_PROTO),
            frm(41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b1, ST_TRUNC),
            frm(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h50, 1'b0, ST_OK),
            // TCP ends inside the port fields
            frm(36, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 1'b1, ST_TRUNC),
            frm(54, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 1'b0, ST_OK),
            // data offset below minimum counts as 5 words
            frm(60, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h0F, 1'b0, ST_OK),
            frm(60, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'hF0, 1'b1, ST_TRUNC),
            frm(133, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 8'hF0, 1'b1, ST_TRUNC),
            frm(134, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 8'hFF, 1'b0, ST_OK),
            // IHL below minimum counts as 5 words; version nibble is ignored
            frm(50, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, 8'h00, 1'b0, ST_OK),
            frm(82, ETHERTYPE_IPV4, 8'hFF, PROTO_UDP, 8'h00, 1'b0, ST_OK),
            frm(42, ETHERTYPE_IPV4, 8'h03, PROTO_UDP, 8'h00, 1'b0, ST_OK)
        };
        f = frm(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 1'b0, ST_OK);
        f.sip   = '0;
        f.dip   = '1;
        f.sport = '0;
        f.dport = '1;
        dir_tab.push_back(f);
        f.sip   = '1;
        f.dip   = '0;
        f.sport = '1;
        f.dport = '0;
        dir_tab.push_back(f);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            quiet = (dir_tab[k].len > HDR_SPAN);
            send_frame(dir_tab[k]);
        end
        quiet = 1'b0;
        wait_results();

        rand_bytes = 0;
        while (rand_bytes < 400) begin
            f = rnd_frame();
            quiet = ($urandom_range(0, 4) == 0);
            send_frame(f);
            rand_bytes += f.len;
            if ($urandom_range(0, 19) == 0)
                wait_results();
        end
        quiet = 1'b0;

        wait_results();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("[eth_ipv4_l4_header_parser] OK");
        else
            $display("[eth_ipv4_l4_header_parser] ERROR");
        $finish;
    end

endmodule
